[rtl/core/fcrd_pkg.sv]
// Shared types and constants for the framed command receiver/decoder.
// Used by every core module; no dependencies.

package fcrd_pkg;

    localparam logic [7:0] DELIM_BYTE = 8'hFF;
    localparam logic [7:0] MAX_ANGLE  = 8'd180;
    localparam logic [7:0] MAX_SPEED  = 8'd10;
    localparam logic [2:0] FRAME_LEN  = 3'd3;
    localparam logic [2:0] COUNT_SAT  = 3'd4;

    // command opcodes (first frame byte)
    localparam logic [7:0] CMD_DRIVE   = 8'h00;
    localparam logic [7:0] CMD_SERVO   = 8'h01;
    localparam logic [7:0] CMD_SPEED   = 8'h02;
    localparam logic [7:0] CMD_LIGHT   = 8'h04;
    localparam logic [7:0] CMD_MODE    = 8'h13;
    localparam logic [7:0] CMD_SAVE    = 8'h32;
    localparam logic [7:0] CMD_RESTORE = 8'h33;

    // speed select (second byte of a speed command)
    localparam logic [7:0] SPD_LEFT  = 8'd1;
    localparam logic [7:0] SPD_RIGHT = 8'd2;

    // second byte of a drive command: fixed-speed arcs
    localparam logic [7:0] ARC_FWD_LEFT   = 8'd5;
    localparam logic [7:0] ARC_BACK_LEFT  = 8'd6;
    localparam logic [7:0] ARC_FWD_RIGHT  = 8'd7;
    localparam logic [7:0] ARC_BACK_RIGHT = 8'd8;

    // second byte of a light command that turns it on
    localparam logic [7:0] LIGHT_ON_CODE = 8'd1;

    localparam logic [7:0] FIRST_SERVO = 8'd1;

    // action codes
    localparam logic [2:0] ACT_IGNORE  = 3'd0;
    localparam logic [2:0] ACT_DRIVE   = 3'd1;
    localparam logic [2:0] ACT_SERVO   = 3'd2;
    localparam logic [2:0] ACT_SPEED   = 3'd3;
    localparam logic [2:0] ACT_LIGHT   = 3'd4;
    localparam logic [2:0] ACT_MODE    = 3'd5;
    localparam logic [2:0] ACT_SAVE    = 3'd6;
    localparam logic [2:0] ACT_RESTORE = 3'd7;

    // direction codes
    localparam logic [2:0] DIR_STOP    = 3'd0;
    localparam logic [2:0] DIR_FORWARD = 3'd1;
    localparam logic [2:0] DIR_BACK    = 3'd2;

    // fixed turn speeds
    localparam logic [3:0] TURN_SLOW = 4'd4;
    localparam logic [3:0] TURN_FAST = 4'd10;

    localparam logic [7:0] MAX_MODE  = 8'd4;
    localparam logic [7:0] MAX_SERVO = 8'd8;
    localparam logic [7:0] MAX_DIR   = 8'd4;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } frame_t;

    typedef struct packed {
        logic       receiving;
        logic [2:0] count;
    } fr_status_t;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] direction;
        logic [3:0] left_drive;
        logic [3:0] right_drive;
        logic [3:0] servo_number;
        logic [7:0] servo_angle;
        logic       light_on;
        logic [2:0] mode;
    } result_t;

endpackage

[rtl/core/framed_command_receiver_decoder_core.sv]
// Top level of the framed command receiver/decoder.
// Depends on fcrd_pkg, fcrd_framer, fcrd_decode and fcrd_outbuf.
//
//   channel   handshake              payload
//   -------   --------------------   ----------------------------------------
//   input     in_valid / in_ready    rx_byte
//   output    out_valid / out_ready  action, direction, left_drive,
//                                    right_drive, servo_number, servo_angle,
//                                    light_on, mode
//
// One byte is taken per cycle while in_ready is high. A closing delimiter of a
// three-byte frame is decoded in the cycle it is taken and shows the next cycle
// unless it waits in the skid entry behind the output register; in_ready drops
// only while both hold results. Reset clears frame tracking, speeds and mode.

module framed_command_receiver_decoder_core
    import fcrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] action,
    output logic [2:0] direction,
    output logic [3:0] left_drive,
    output logic [3:0] right_drive,
    output logic [3:0] servo_number,
    output logic [7:0] servo_angle,
    output logic       light_on,
    output logic [2:0] mode
);

    logic       in_fire;
    logic       close3;
    frame_t     frame;
    fr_status_t fr_status;
    result_t    dec_res;
    result_t    out_res;

    assign in_fire = in_valid && in_ready;

    fcrd_framer u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (in_fire),
        .rx_byte (rx_byte),
        .frame   (frame),
        .status  (fr_status),
        .close3  (close3)
    );

    fcrd_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (close3),
        .frame (frame),
        .res   (dec_res)
    );

    fcrd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (close3),
        .push_data (dec_res),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

    assign action       = out_res.action;
    assign direction    = out_res.direction;
    assign left_drive   = out_res.left_drive;
    assign right_drive  = out_res.right_drive;
    assign servo_number = out_res.servo_number;
    assign servo_angle  = out_res.servo_angle;
    assign light_on     = out_res.light_on;
    assign mode         = out_res.mode;

    // frame count stays within saturation while receiving, zero when idle
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fr_status.count <= COUNT_SAT) && (fr_status.receiving || fr_status.count == 3'd0))
        else $error("frame byte count out of range");

    // a result leaves the decoder only on a closing delimiter of a full frame
    a_close_only: assert property (@(posedge clk) disable iff (!rst_n)
        close3 |-> (fr_status.receiving && fr_status.count == FRAME_LEN
                    && rx_byte == DELIM_BYTE))
        else $error("decode fired outside a three-byte frame");

    // a result taken while the output is empty shows up next cycle
    a_result_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (close3 && !out_valid) |=> out_valid)
        else $error("decoded result lost");

    // reported speeds and mode stay in their legal ranges
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_drive <= 4'd10 && right_drive <= 4'd10 && mode <= 3'd4))
        else $error("result speed or mode out of range");

endmodule

[rtl/core/fcrd_framer.sv]
// Frame collector: tracks delimiters, stores the three payload bytes.
// Depends on fcrd_pkg.

module fcrd_framer
    import fcrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] rx_byte,
    output frame_t     frame,
    output fr_status_t status,
    output logic       close3
);

    logic       receiving_reg;
    logic       receiving_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [7:0] bytes_reg [3];
    logic       is_delim;
    logic       store;

    assign is_delim = (rx_byte == DELIM_BYTE);
    assign store    = fire && receiving_reg && !is_delim && (count_reg < FRAME_LEN);
    assign close3   = fire && receiving_reg && is_delim && (count_reg == FRAME_LEN);

    always_comb
    begin
        receiving_next = receiving_reg;
        count_next     = count_reg;
        if (fire)
        begin
            if (!receiving_reg)
            begin
                if (is_delim)
                begin
                    receiving_next = 1'b1;
                    count_next     = '0;
                end
            end
            else if (is_delim)
            begin
                receiving_next = 1'b0;
                count_next     = '0;
            end
            else if (count_reg < COUNT_SAT)
            begin
                // saturate so long frames never match
                count_next = count_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            receiving_reg <= receiving_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            bytes_reg[count_reg[1:0]] <= rx_byte;
        end
    end

    assign frame.b0 = bytes_reg[0];
    assign frame.b1 = bytes_reg[1];
    assign frame.b2 = bytes_reg[2];

    assign status.receiving = receiving_reg;
    assign status.count     = count_reg;

endmodule

[rtl/core/fcrd_decode.sv]
// Command decoder: holds wheel speeds and cruise mode, decodes one frame.
// Depends on fcrd_pkg.

module fcrd_decode
    import fcrd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  frame_t  frame,
    output result_t res
);

    logic [3:0] left_now_reg;
    logic [3:0] left_now_next;
    logic [3:0] right_now_reg;
    logic [3:0] right_now_next;
    logic [3:0] left_held_reg;
    logic [3:0] left_held_next;
    logic [3:0] right_held_reg;
    logic [3:0] right_held_next;
    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic       left_slow;

    assign left_slow = (frame.b1 == ARC_FWD_LEFT) || (frame.b1 == ARC_BACK_LEFT);

    always_comb
    begin
        left_now_next   = left_now_reg;
        right_now_next  = right_now_reg;
        left_held_next  = left_held_reg;
        right_held_next = right_held_reg;
        mode_next       = mode_reg;
        res             = '0;
        res.action      = ACT_IGNORE;

        unique case (frame.b0)
            CMD_DRIVE:
            begin
                if (frame.b1 <= MAX_DIR)
                begin
                    left_now_next  = left_held_reg;
                    right_now_next = right_held_reg;
                    res.action     = ACT_DRIVE;
                    res.direction  = frame.b1[2:0];
                end
                else if (frame.b1 <= ARC_BACK_RIGHT)
                begin
                    // fixed-speed turns while moving
                    left_now_next  = left_slow ? TURN_SLOW : TURN_FAST;
                    right_now_next = left_slow ? TURN_FAST : TURN_SLOW;
                    res.action     = ACT_DRIVE;
                    res.direction  = ((frame.b1 == ARC_FWD_LEFT)
                                      || (frame.b1 == ARC_FWD_RIGHT))
                                     ? DIR_FORWARD : DIR_BACK;
                end
            end
            CMD_SERVO:
            begin
                if ((frame.b2 <= MAX_ANGLE) && (frame.b1 >= FIRST_SERVO)
                    && (frame.b1 <= MAX_SERVO))
                begin
                    res.action       = ACT_SERVO;
                    res.servo_number = frame.b1[3:0];
                    res.servo_angle  = frame.b2;
                end
            end
            CMD_SPEED:
            begin
                if (frame.b2 <= MAX_SPEED)
                begin
                    if (frame.b1 == SPD_LEFT)
                    begin
                        left_now_next  = frame.b2[3:0];
                        left_held_next = frame.b2[3:0];
                        res.action     = ACT_SPEED;
                    end
                    else if (frame.b1 == SPD_RIGHT)
                    begin
                        right_now_next  = frame.b2[3:0];
                        right_held_next = frame.b2[3:0];
                        res.action      = ACT_SPEED;
                    end
                end
            end
            CMD_LIGHT:
            begin
                res.action   = ACT_LIGHT;
                res.light_on = (frame.b1 == LIGHT_ON_CODE);
            end
            CMD_MODE:
            begin
                mode_next  = (frame.b1 <= MAX_MODE) ? frame.b1[2:0] : 3'd0;
                res.action = ACT_MODE;
            end
            CMD_SAVE:
            begin
                res.action = ACT_SAVE;
            end
            CMD_RESTORE:
            begin
                res.action = ACT_RESTORE;
            end
            default:
            begin
                res.action = ACT_IGNORE;
            end
        endcase

        res.left_drive  = left_now_next;
        res.right_drive = right_now_next;
        res.mode        = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_now_reg   <= '0;
            right_now_reg  <= '0;
            left_held_reg  <= '0;
            right_held_reg <= '0;
            mode_reg       <= '0;
        end
        else if (en)
        begin
            left_now_reg   <= left_now_next;
            right_now_reg  <= right_now_next;
            left_held_reg  <= left_held_next;
            right_held_reg <= right_held_next;
            mode_reg       <= mode_next;
        end
    end

endmodule

[rtl/core/fcrd_outbuf.sv]
// Two-entry result buffer (output register plus skid stage).
// Depends on fcrd_pkg.

module fcrd_outbuf
    import fcrd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    can_push,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            // park behind a stalled result
            if (out_valid_reg)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

endmodule
